// File: hdl/agmwu_pkg.sv
// ----------------------------------------------------------------------------
// agmwu_pkg
// shared types, constants and helpers for the adaptive gain momentum update
// ----------------------------------------------------------------------------
package agmwu_pkg;

	// field widths fixed by the interface
	localparam int ADDR_W   = 12;
	localparam int DATA_W   = 32;
	localparam int MOM_W    = 16;
	localparam int RATE_W   = 24;
	localparam int CFG_IDX_W = 3;

	// parameter defaults
	localparam int ENTRIES_DEF = 4096;
	localparam int LAYERS_DEF  = 4;

	// gain constants, unsigned q8.24 / q0.24
	localparam logic [31:0] GAIN_ONE   = 32'd16777216;
	localparam logic [23:0] GAIN_STEP  = 24'd838861;
	localparam logic [23:0] GAIN_DECAY = 24'd15938355;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_BASE = 3'd1;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_UPDATE = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	// one store word
	typedef struct packed {
		logic        has_prev;
		logic [31:0] prev_grad;
		logic [31:0] gain;
		logic [31:0] delta;
		logic [31:0] weight;
	} entry_t;

	// one result beat
	typedef struct packed {
		logic [31:0] weight;
		logic [31:0] delta;
		logic [31:0] gain;
		logic        sat;
	} result_t;

	// clamp a 33-bit signed sum to the signed 32-bit range
	function automatic logic [31:0] clip_s33(input logic [32:0] x);
		logic [31:0] r;
		if (x[32] != x[31]) begin
			r = x[32] ? S32_MIN : S32_MAX;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/agmwu_store.sv
// ----------------------------------------------------------------------------
// agmwu_store
// single-port-write, single-port-read synchronous store, registered read data
// ----------------------------------------------------------------------------
module agmwu_store #(
	parameter int DEPTH = agmwu_pkg::ENTRIES_DEF,
	parameter int WIDTH = $bits(agmwu_pkg::entry_t)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/agmwu_calc.sv
// ----------------------------------------------------------------------------
// agmwu_calc
// five-stage arithmetic for one item: gain adapt, effective rate, gradient
// term, delta, weight; builds the write-back word and the result
// ----------------------------------------------------------------------------
module agmwu_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  agmwu_pkg::entry_t    entry,
	input  logic [1:0]           op,
	input  logic signed [31:0]   grad,
	input  logic [23:0]          rate,
	input  logic [15:0]          momentum,
	output logic                 done,
	output agmwu_pkg::entry_t    wb_entry,
	output logic                 wb_en,
	output agmwu_pkg::result_t   res
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: gain adaptation and momentum term
	logic               g_pos, g_neg, p_pos, p_neg, same_sign;
	logic [32:0]        gain_inc;
	logic [55:0]        gain_dec;
	logic [31:0]        gain_n;
	logic               gsat_n;
	logic signed [48:0] mom_prod;

	always_comb begin
		g_pos     = !grad[31] && (grad != 32'sd0);
		g_neg     = grad[31];
		p_pos     = !entry.prev_grad[31] && (entry.prev_grad != 32'd0);
		p_neg     = entry.prev_grad[31];
		same_sign = (p_pos && g_pos) || (p_neg && g_neg);
		gain_inc  = {1'b0, entry.gain} + {9'd0, agmwu_pkg::GAIN_STEP};
		gain_dec  = 56'(entry.gain) * 56'(agmwu_pkg::GAIN_DECAY);
		gain_n    = entry.gain;
		gsat_n    = 1'b0;
		if (entry.has_prev) begin
			if (same_sign) begin
				gain_n = gain_inc[32] ? 32'hffff_ffff : gain_inc[31:0];
				gsat_n = gain_inc[32];
			end else begin
				gain_n = gain_dec[55:24];
			end
		end
		mom_prod = 49'($signed(entry.delta)) * 49'($signed({1'b0, momentum}));
	end

	agmwu_pkg::entry_t  old_s1;
	logic [1:0]         op_s1;
	logic signed [31:0] grad_s1;
	logic [23:0]        rate_s1;
	logic [31:0]        gain_s1;
	logic [31:0]        mom_s1;
	logic               sat_s1;

	always_ff @(posedge clk) begin
		if (start) begin
			old_s1  <= entry;
			op_s1   <= op;
			grad_s1 <= grad;
			rate_s1 <= rate;
			gain_s1 <= gain_n;
			mom_s1  <= mom_prod[47:16];
			sat_s1  <= gsat_n;
		end
	end

	// stage 2: effective rate
	logic [55:0] eff_prod;
	assign eff_prod = 56'(rate_s1) * 56'(gain_s1);

	agmwu_pkg::entry_t  old_s2;
	logic [1:0]         op_s2;
	logic signed [31:0] grad_s2;
	logic [31:0]        gain_s2;
	logic [31:0]        mom_s2;
	logic               sat_s2;
	logic [31:0]        eff_s2;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			old_s2  <= old_s1;
			op_s2   <= op_s1;
			grad_s2 <= grad_s1;
			gain_s2 <= gain_s1;
			mom_s2  <= mom_s1;
			sat_s2  <= sat_s1;
			eff_s2  <= eff_prod[55:24];
		end
	end

	// stage 3: gradient term, floor then clamp
	logic signed [64:0] gt_prod;
	logic [40:0]        gt_sh;
	logic               gt_ovf;
	logic [31:0]        gt_n;

	always_comb begin
		gt_prod = 65'($signed({1'b0, eff_s2})) * 65'(grad_s2);
		gt_sh   = gt_prod[64:24];
		gt_ovf  = !((gt_sh[40:31] == '0) || (gt_sh[40:31] == '1));
		gt_n    = gt_ovf ? (gt_sh[40] ? agmwu_pkg::S32_MIN : agmwu_pkg::S32_MAX)
			: gt_sh[31:0];
	end

	agmwu_pkg::entry_t  old_s3;
	logic [1:0]         op_s3;
	logic signed [31:0] grad_s3;
	logic [31:0]        gain_s3;
	logic [31:0]        mom_s3;
	logic               sat_s3;
	logic [31:0]        gt_s3;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			old_s3  <= old_s2;
			op_s3   <= op_s2;
			grad_s3 <= grad_s2;
			gain_s3 <= gain_s2;
			mom_s3  <= mom_s2;
			sat_s3  <= sat_s2 | gt_ovf;
			gt_s3   <= gt_n;
		end
	end

	// stage 4: new delta
	logic [32:0] nd_sum;
	assign nd_sum = {mom_s3[31], mom_s3} + {gt_s3[31], gt_s3};

	agmwu_pkg::entry_t  old_s4;
	logic [1:0]         op_s4;
	logic signed [31:0] grad_s4;
	logic [31:0]        gain_s4;
	logic               sat_s4;
	logic [31:0]        nd_s4;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			old_s4  <= old_s3;
			op_s4   <= op_s3;
			grad_s4 <= grad_s3;
			gain_s4 <= gain_s3;
			sat_s4  <= sat_s3 | (nd_sum[32] != nd_sum[31]);
			nd_s4   <= agmwu_pkg::clip_s33(nd_sum);
		end
	end

	// stage 5: new weight and result assembly
	logic [32:0]        nw_sum;
	logic [31:0]        nw;
	agmwu_pkg::entry_t  wb_n;
	agmwu_pkg::result_t res_n;
	logic               wb_en_n;

	always_comb begin
		nw_sum  = {old_s4.weight[31], old_s4.weight} + {nd_s4[31], nd_s4};
		nw      = agmwu_pkg::clip_s33(nw_sum);
		wb_n    = old_s4;
		res_n   = '{weight: old_s4.weight, delta: old_s4.delta,
			gain: old_s4.gain, sat: 1'b0};
		wb_en_n = 1'b0;
		case (agmwu_pkg::opcode_t'(op_s4))
			agmwu_pkg::OP_LOAD: begin
				wb_n    = '{has_prev: 1'b0, prev_grad: 32'd0,
					gain: agmwu_pkg::GAIN_ONE, delta: 32'd0, weight: grad_s4};
				res_n   = '{weight: grad_s4, delta: 32'd0,
					gain: agmwu_pkg::GAIN_ONE, sat: 1'b0};
				wb_en_n = 1'b1;
			end
			agmwu_pkg::OP_UPDATE: begin
				wb_n    = '{has_prev: 1'b1, prev_grad: grad_s4,
					gain: gain_s4, delta: nd_s4, weight: nw};
				res_n   = '{weight: nw, delta: nd_s4, gain: gain_s4,
					sat: sat_s4 | (nw_sum[32] != nw_sum[31])};
				wb_en_n = 1'b1;
			end
			default: begin
				wb_en_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			wb_entry <= wb_n;
			wb_en    <= wb_en_n;
			res      <= res_n;
		end
	end

	// stage valids, one item in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign done = v_s5;

endmodule

// File: hdl/adaptive_gain_momentum_weight_update_core.sv
// result path: the fold states, the store read, the five arithmetic stages, then the output register
// one item at a time, no new item before the last is done; in_ready is high only in idle, and the
//   store read, the five arithmetic stages and the write-back run per item
// a finished result waits in the output register while the next item runs
// reset: asynchronous, clears control and configuration; the store is not
//   cleared and an entry holds nothing defined until a load writes it
// ----------------------------------------------------------------------------
// adaptive_gain_momentum_weight_update_core
// per-entry optimizer store: delta-bar-delta gain with momentum weight update
// ----------------------------------------------------------------------------
module adaptive_gain_momentum_weight_update_core #(
	parameter int ENTRIES = agmwu_pkg::ENTRIES_DEF,
	parameter int LAYERS  = agmwu_pkg::LAYERS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_write,
	input  logic [agmwu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [agmwu_pkg::RATE_W-1:0]      cfg_data,
	// input beats
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [agmwu_pkg::ADDR_W-1:0]      entry_address,
	input  logic [1:0]                        layer_select,
	input  logic signed [agmwu_pkg::DATA_W-1:0] value,
	// result beats
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [agmwu_pkg::DATA_W-1:0] weight_out,
	output logic signed [agmwu_pkg::DATA_W-1:0] delta_out,
	output logic [agmwu_pkg::DATA_W-1:0]      gain_out,
	output logic                              saturated
);

	localparam int AW = $clog2(ENTRIES);
	// floor reciprocal of the depth, q.24, for the address fold
	localparam logic [24:0] RECIP = 25'((2 ** 24) / ENTRIES);
	localparam logic [1:0]  LAST_LAYER = 2'(LAYERS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RED,
		ST_FEED,
		ST_CALC,
		ST_HOLD
	} state_t;

	state_t state_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [agmwu_pkg::MOM_W-1:0]  momentum_q;
	logic [agmwu_pkg::RATE_W-1:0] rate_q [LAYERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			momentum_q <= '0;
			for (int l = 0; l < LAYERS; l++) begin
				rate_q[l] <= '0;
			end
		end else if (cfg_write) begin
			if (cfg_index == agmwu_pkg::CFG_MOMENTUM) begin
				momentum_q <= cfg_data[agmwu_pkg::MOM_W-1:0];
			end
			for (int l = 0; l < LAYERS; l++) begin
				if (cfg_index == agmwu_pkg::CFG_RATE_BASE + 3'(l)) begin
					rate_q[l] <= cfg_data;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// captured item
	// ------------------------------------------------------------------
	logic [1:0]                   op_q;
	logic [agmwu_pkg::ADDR_W-1:0] addr_q;
	logic [1:0]                   layer_q;
	logic signed [31:0]           value_q;
	logic [12:0]                  quot_q;
	logic [AW-1:0]                addr_red_q;

	// address fold: quotient estimate is exact or one low
	logic [36:0] quot_prod;
	logic [33:0] rem_raw;
	logic [33:0] rem_fix;
	logic [AW-1:0] addr_red;

	always_comb begin
		quot_prod = 37'(addr_q) * 37'(RECIP);
		rem_raw   = 34'(addr_q) - 34'(quot_q) * 34'(ENTRIES);
		rem_fix   = (rem_raw >= 34'(ENTRIES)) ? rem_raw - 34'(ENTRIES) : rem_raw;
		addr_red  = rem_fix[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= opcode;
			addr_q  <= entry_address;
			layer_q <= layer_select;
			value_q <= value;
		end
		if (state_q == ST_DIV) begin
			quot_q <= quot_prod[36:24];
		end
		if (state_q == ST_RED) begin
			addr_red_q <= addr_red;
		end
	end

	// layers past the last one use the last rate
	logic [1:0]                   layer_clamp;
	logic [agmwu_pkg::RATE_W-1:0] rate_sel;

	always_comb begin
		layer_clamp = (layer_q > LAST_LAYER) ? LAST_LAYER : layer_q;
		rate_sel    = '0;
		for (int l = 0; l < LAYERS; l++) begin
			if (layer_clamp == 2'(l)) begin
				rate_sel = rate_q[l];
			end
		end
	end

	// ------------------------------------------------------------------
	// entry store: read in the fold cycle, written back once per load or update item
	// ------------------------------------------------------------------
	agmwu_pkg::entry_t  rd_entry;
	agmwu_pkg::entry_t  wb_entry;
	logic               wb_en;
	logic               calc_done;
	agmwu_pkg::result_t calc_res;
	logic               mem_we;

	// the write lands before idle, so the next read always sees it
	assign mem_we = (state_q == ST_CALC) && calc_done && wb_en;

	agmwu_store #(
		.DEPTH (ENTRIES),
		.WIDTH ($bits(agmwu_pkg::entry_t))
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_red_q),
		.wdata (wb_entry),
		.re    (state_q == ST_RED),
		.raddr (addr_red),
		.rdata (rd_entry)
	);

	agmwu_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_FEED),
		.entry    (rd_entry),
		.op       (op_q),
		.grad     (value_q),
		.rate     (rate_sel),
		.momentum (momentum_q),
		.done     (calc_done),
		.wb_entry (wb_entry),
		.wb_en    (wb_en),
		.res      (calc_res)
	);

	// ------------------------------------------------------------------
	// sequencer and output register
	// ------------------------------------------------------------------
	logic               out_valid_q;
	agmwu_pkg::result_t out_res_q;
	logic               out_free;
	logic               deliver;

	assign out_free = !out_valid_q || out_ready;
	// a finished result moves into the output register once the slot frees up
	assign deliver  = ((state_q == ST_CALC && calc_done) || state_q == ST_HOLD)
		&& out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (deliver) begin
				out_valid_q <= 1'b1;
				out_res_q   <= calc_res;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					state_q <= ST_FEED;
				end
				ST_FEED: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (calc_done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					// calc result stays put in its last stage
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign weight_out = $signed(out_res_q.weight);
	assign delta_out  = $signed(out_res_q.delta);
	assign gain_out   = out_res_q.gain;
	assign saturated  = out_res_q.sat;

endmodule

// File: hdl/agmwu_checker.sv
// ----------------------------------------------------------------------------
// agmwu_checker
// port-level checks on the core, attached by bind
// ----------------------------------------------------------------------------
module agmwu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] weight_out,
	input logic [31:0] delta_out,
	input logic [31:0] gain_out,
	input logic        saturated
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight_out)
			&& $stable(delta_out) && $stable(gain_out) && $stable(saturated))
		else $error("result beat changed while stalled");

	// no new item while one is being worked on
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##7 !in_ready)
		else $error("input taken while an item is in flight");

	// a result only appears while the core is busy
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result beat with no item in flight");

	// the core returns to idle right after it presents a result
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("core not idle after delivering a result");

endmodule

bind adaptive_gain_momentum_weight_update_core agmwu_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.weight_out (weight_out),
	.delta_out  (delta_out),
	.gain_out   (gain_out),
	.saturated  (saturated)
);
